// ----- sv/et_pkg.sv -----
// Shared types for the Euler totient block.
`timescale 1ns / 1ps

package et_pkg;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_EVAL,
      ST_MUL,
      ST_DONE
   } state_type;

   // Purpose of the division in flight, which decides the step after it.
   typedef enum logic [1:0] {
      OP_TEST,
      OP_RES,
      OP_STRIP,
      OP_FIN
   } op_type;

endpackage

// ----- sv/euler_totient_top.sv -----
// Euler totient by trial division with a bit-serial divider and multiplier.
`timescale 1ns / 1ps
//
// One request on the req_ channel carries an unsigned value; one result on the
// rsp_ channel carries phi(value) in rsp_tdata and an invalid flag in rsp_tuser.
// A value of zero gives a totient of zero with the flag set.
// The value is factored by trial division with divisors 2, 3, 4, ... while the
// divisor does not exceed cofactor / divisor. Every division runs through one
// restoring divider that produces one quotient bit per cycle. Each distinct prime
// also costs one more division and a shift-add multiplication. One request is
// worked on at a time.
// A finished result sits in an output register, so the next request is taken
// while the receiver stalls; a second result waits until that register is free.
// Reset returns the sequencer to idle and drops any result not yet taken.
//
module euler_totient_top
   import et_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [((WIDTH + 7) / 8) * 8 - 1:0] req_tdata,  // value
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [((WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,  // totient
   output logic                              rsp_tuser   // invalid
);

   localparam int DATA_W = ((WIDTH + 7) / 8) * 8;
   localparam int CNT_W  = $clog2(WIDTH);

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [WIDTH-1:0]   rest_ff, rest_in;
   logic [WIDTH-1:0]   res_ff, res_in;
   logic [WIDTH-1:0]   d_ff, d_in;
   logic               inv_ff, inv_in;
   logic [WIDTH-1:0]   dvd_ff, dvd_in;    // dividend, then quotient
   logic [WIDTH-1:0]   rem_ff, rem_in;
   logic [WIDTH-1:0]   dvs_ff, dvs_in;
   logic [WIDTH-1:0]   mcand_ff, mcand_in;
   logic [WIDTH-1:0]   mplier_ff, mplier_in;
   logic [WIDTH-1:0]   acc_ff, acc_in;
   logic [WIDTH-1:0]   out_data_ff, out_data_in;
   logic               out_inv_ff, out_inv_in;
   logic               out_valid_ff, out_valid_in;

   logic [WIDTH:0]     shifted;
   logic [WIDTH:0]     diff;
   logic [WIDTH-1:0]   acc_next;
   logic [WIDTH-1:0]   d_inc;
   logic               div_start;
   logic [WIDTH-1:0]   div_dvd;
   logic [WIDTH-1:0]   div_dvs;
   op_type             div_op;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = DATA_W'(out_data_ff);
   assign rsp_tuser  = out_inv_ff;

   // One restoring division step: bring in the next dividend bit and subtract.
   assign shifted  = {rem_ff, dvd_ff[WIDTH-1]};
   assign diff     = shifted - {1'b0, dvs_ff};
   assign acc_next = mplier_ff[0] ? (acc_ff + mcand_ff) : acc_ff;
   assign d_inc    = d_ff + WIDTH'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      op_ff       <= op_in;
      cnt_ff      <= cnt_in;
      rest_ff     <= rest_in;
      res_ff      <= res_in;
      d_ff        <= d_in;
      inv_ff      <= inv_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      acc_ff      <= acc_in;
      out_data_ff <= out_data_in;
      out_inv_ff  <= out_inv_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      rest_in      = rest_ff;
      res_in       = res_ff;
      d_in         = d_ff;
      inv_in       = inv_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      acc_in       = acc_ff;
      out_data_in  = out_data_ff;
      out_inv_in   = out_inv_ff;
      out_valid_in = out_valid_ff & ~rsp_tready;
      div_start    = 1'b0;
      div_dvd      = rest_ff;
      div_dvs      = d_ff;
      div_op       = OP_TEST;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               rest_in = req_tdata[WIDTH-1:0];
               res_in  = req_tdata[WIDTH-1:0];
               d_in    = WIDTH'(2);
               if (req_tdata[WIDTH-1:0] == '0) begin
                  inv_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  inv_in    = 1'b0;
                  div_start = 1'b1;
                  div_dvd   = req_tdata[WIDTH-1:0];
                  div_dvs   = WIDTH'(2);
                  div_op    = OP_TEST;
               end
            end
         end

         ST_DIV: begin
            if (!diff[WIDTH]) begin
               rem_in = diff[WIDTH-1:0];
               dvd_in = {dvd_ff[WIDTH-2:0], 1'b1};
            end else begin
               rem_in = shifted[WIDTH-1:0];
               dvd_in = {dvd_ff[WIDTH-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_EVAL;
            end
         end

         // Quotient in dvd_ff, remainder in rem_ff.
         ST_EVAL: begin
            unique case (op_ff)
               OP_TEST: begin
                  if (d_ff > dvd_ff) begin
                     // Trial division is over; a cofactor above one is prime.
                     if (rest_ff > WIDTH'(1)) begin
                        div_start = 1'b1;
                        div_dvd   = res_ff;
                        div_dvs   = rest_ff;
                        div_op    = OP_FIN;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end else if (rem_ff == '0) begin
                     rest_in   = dvd_ff;
                     div_start = 1'b1;
                     div_dvd   = res_ff;
                     div_dvs   = d_ff;
                     div_op    = OP_RES;
                  end else begin
                     d_in      = d_inc;
                     div_start = 1'b1;
                     div_dvd   = rest_ff;
                     div_dvs   = d_inc;
                     div_op    = OP_TEST;
                  end
               end
               OP_RES, OP_FIN: begin
                  mcand_in  = dvd_ff;
                  mplier_in = (op_ff == OP_RES) ? (d_ff - WIDTH'(1))
                                                : (rest_ff - WIDTH'(1));
                  acc_in    = '0;
                  cnt_in    = CNT_W'(WIDTH - 1);
                  state_in  = ST_MUL;
               end
               OP_STRIP: begin
                  if (rem_ff == '0) begin
                     rest_in   = dvd_ff;
                     div_start = 1'b1;
                     div_dvd   = dvd_ff;
                     div_dvs   = d_ff;
                     div_op    = OP_STRIP;
                  end else begin
                     d_in      = d_inc;
                     div_start = 1'b1;
                     div_dvd   = rest_ff;
                     div_dvs   = d_inc;
                     div_op    = OP_TEST;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_MUL: begin
            acc_in    = acc_next;
            mcand_in  = {mcand_ff[WIDTH-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[WIDTH-1:1]};
            cnt_in    = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               res_in = acc_next;
               if (op_ff == OP_FIN) begin
                  state_in = ST_DONE;
               end else begin
                  // The cofactor was already divided once; keep stripping.
                  div_start = 1'b1;
                  div_dvd   = rest_ff;
                  div_dvs   = d_ff;
                  div_op    = OP_STRIP;
               end
            end
         end

         ST_DONE: begin
            if (!out_valid_ff || rsp_tready) begin
               out_data_in  = inv_ff ? '0 : res_ff;
               out_inv_in   = inv_ff;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (div_start) begin
         dvd_in   = div_dvd;
         dvs_in   = div_dvs;
         rem_in   = '0;
         op_in    = div_op;
         cnt_in   = CNT_W'(WIDTH - 1);
         state_in = ST_DIV;
      end
   end

   // The partial remainder of a restoring divider stays below the divisor.
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < dvs_ff))
      else $error("partial remainder reached the divisor");

   // Trial divisors start at two and only grow.
   a_divisor_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL && op_ff == OP_TEST) |-> (d_ff >= WIDTH'(2)))
      else $error("trial divisor below two");

   // An invalid result always carries a zero totient.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_inv_ff) |-> (out_data_ff == '0))
      else $error("invalid result with nonzero totient");

   // The totient of a positive value is never zero.
   a_valid_nonzero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_inv_ff) |-> (out_data_ff != '0))
      else $error("zero totient for a positive value");

endmodule

// ----- sim/tb_euler_totient_top.sv -----
// Self-checking testbench for the Euler totient block on its request and response streams.
`timescale 1ns / 1ps

module tb_euler_totient_top;

   localparam int WIDTH = 32;
   localparam int DATA_BITS = ((WIDTH + 7) / 8) * 8;
   localparam int RANDOM_ITEMS = 77;
   localparam int HOLD_AT_RESULT = 30;
   localparam int HOLD_CYCLES = 30000;
   localparam int DRAIN_AT_ITEM = 50;

   typedef struct {
      logic [WIDTH-1:0] value;
      bit               drain_first;
   } pending_type;

   typedef struct {
      logic [WIDTH-1:0] totient;
      logic             invalid;
   } totient_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_BITS-1:0] req_tdata = '0;  // value
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DATA_BITS-1:0] rsp_tdata;       // totient
   logic                 rsp_tuser;       // invalid

   pending_type pending_values[$];
   totient_type expected_totients[$];
   int unsigned results_seen = 0;
   int unsigned hold_cycles = 0;
   bit          hold_taken = 1'b0;
   int unsigned send_gap = 0;
   int unsigned take_gap = 0;
   int unsigned mismatch_count = 0;

   euler_totient_top #(
      .WIDTH(WIDTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Trial division with the bound written as a quotient so it never overflows.
   function automatic totient_type predict_totient(logic [WIDTH-1:0] value);
      longint unsigned rest;
      longint unsigned phi;
      longint unsigned divisor;
      totient_type     result;
      rest = 64'(value);
      phi = 64'(value);
      divisor = 64'd2;
      result.invalid = (value == '0);
      if (value != '0) begin
         while (divisor <= rest / divisor) begin
            if (rest % divisor == 64'd0) begin
               phi = phi / divisor * (divisor - 64'd1);
               while (rest % divisor == 64'd0) rest = rest / divisor;
            end
            divisor++;
         end
         if (rest > 64'd1) phi = phi / rest * (rest - 64'd1);
      end
      result.totient = phi[WIDTH-1:0];
      return result;
   endfunction

   // Mostly no idling, sometimes a short gap, now and then a long gap.
   function automatic int unsigned idle_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 300);
   endfunction

   // Values with no large prime factor keep the trial division short: one cofactor
   // below 2^14 times a random number of factors no larger than 97.
   function automatic logic [WIDTH-1:0] smooth_value();
      longint unsigned value;
      longint unsigned factor;
      int unsigned     factor_count;
      value = 64'($urandom_range(1, 16383));
      factor_count = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 8);
      for (int i = 0; i < factor_count; i++) begin
         factor = 64'($urandom_range(2, 97));
         if (value * factor < (64'd1 << WIDTH)) value = value * factor;
      end
      return value[WIDTH-1:0];
   endfunction

   // Request driver.
   always @(posedge clock) begin
      pending_type next_item;
      bit          offering;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         offering = req_tvalid;
         if (req_tvalid && req_tready) begin
            expected_totients.insert(expected_totients.size(),
                                     predict_totient(req_tdata[WIDTH-1:0]));
            offering = 1'b0;
         end
         if (!offering) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_values.size() > 0 &&
                         !(pending_values[0].drain_first && expected_totients.size() > 0)) begin
               next_item = pending_values.pop_front();
               req_tdata <= DATA_BITS'(next_item.value);
               offering = 1'b1;
               send_gap = idle_length();
            end
         end
         req_tvalid <= offering;
      end
   end

   // Response monitor and checker.
   always @(posedge clock) begin
      totient_type expected;
      bit          ready_next;
      if (reset) begin
         rsp_tready <= 1'b0;
         take_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen <= results_seen + 1;
            if (expected_totients.size() == 0) begin
               $error("unexpected response: totient %0d invalid %0b",
                      rsp_tdata[WIDTH-1:0], rsp_tuser);
               mismatch_count++;
            end else begin
               expected = expected_totients.pop_front();
               if (rsp_tdata[WIDTH-1:0] !== expected.totient) begin
                  $error("totient: expected %0d, got %0d",
                         expected.totient, rsp_tdata[WIDTH-1:0]);
                  mismatch_count++;
               end
               if (rsp_tuser !== expected.invalid) begin
                  $error("invalid: expected %0b, got %0b", expected.invalid, rsp_tuser);
                  mismatch_count++;
               end
            end
         end
         if (take_gap > 0) begin
            take_gap--;
            ready_next = 1'b0;
         end else if ($urandom_range(0, 4) == 0) begin
            take_gap = idle_length();
            ready_next = (take_gap == 0);
         end else begin
            ready_next = 1'b1;
         end
         rsp_tready <= ready_next && (hold_cycles == 0);
      end
   end

   // One long receiver hold-off so the block fills up and stops taking requests.
   always @(posedge clock) begin
      if (reset) begin
         hold_cycles <= 0;
      end else if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
      end else if (!hold_taken && results_seen == HOLD_AT_RESULT) begin
         hold_cycles <= HOLD_CYCLES;
         hold_taken <= 1'b1;
      end
   end

   initial begin
      logic [WIDTH-1:0] directed_values[$];
      pending_type      entry;
      directed_values = '{
         32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd12, 32'd49, 32'd97, 32'd121,
         32'd128, 32'd255, 32'd65535, 32'd65536, 32'd65537, 32'd196563,
         32'd223092870, 32'd16752649, 32'd16777213,
         32'h8000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555
      };
      foreach (directed_values[i]) begin
         entry.value = directed_values[i];
         entry.drain_first = 1'b0;
         pending_values.insert(pending_values.size(), entry);
      end
      // The first random request waits until the directed part has fully drained.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         entry.value = smooth_value();
         entry.drain_first = (i == 0) || (i == DRAIN_AT_ITEM);
         pending_values.insert(pending_values.size(), entry);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_values.size() > 0 || req_tvalid) @(posedge clock);
      while (expected_totients.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("tb_euler_totient_top OK");
      end else begin
         $display("tb_euler_totient_top NOT OK");
      end
      $finish;
   end

   initial begin
      #200_000_000;
      $display("tb_euler_totient_top NOT OK");
      $finish;
   end

endmodule
